// ----- rtl/ntas_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntas_pkg
// Shared types and constants for the neighbor table aging scan block.
// ----------------------------------------------------------------------------
package ntas_pkg;

    // Slots per table (one table per address family)
    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
    localparam int unsigned CUR_W       = $clog2(TABLE_DEPTH + 1);

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned UPD_W       = 6;
    localparam int unsigned VIS_W       = 12;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned RES_IDX_W   = 10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_THRESH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPD_BUDGET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VISITS    = 3'd4;

    // Configuration reset values
    localparam logic [1:0]        RST_SCAN_MODE     = 2'd0;
    localparam logic [TIME_W-1:0] RST_SCAN_INTERVAL = 32'd60;
    localparam logic [TIME_W-1:0] RST_STALE_THRESH  = 32'd240;
    localparam logic [UPD_W-1:0]  RST_UPD_BUDGET    = 6'd10;
    localparam logic [VIS_W-1:0]  RST_MAX_VISITS    = 12'd100;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CUR_W-1:0] t_cur;

    // Cursor value that marks a family's part of the pass as done
    localparam t_cur CUR_DONE = t_cur'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ACT_ACK    = 2'd0,
        ACT_PROBE  = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_DONE   = 2'd3
    } t_action;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_RUN   = 1'b1
    } t_cmd;

    typedef struct packed {
        logic              valid;
        logic              stat;
        logic [TIME_W-1:0] stamp;
    } t_slot;

endpackage
`default_nettype wire

// ----- rtl/neighbor_table_aging_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// neighbor_table_aging_scan
// Two neighbor tables with a budgeted, resumable aging scan.
// ----------------------------------------------------------------------------
// Each table sits in its own single-port-write, registered-read memory. A
// write command passes through an ack state, from which its ack is loaded
// into the output register. A run walks the enabled tables from their saved
// cursors, one slot at a time (read the slot, then age-compare it in the
// shared subtract/compare unit); a stalled output holds the walk. After reset
// the block clears both tables and holds o_in_stall high meanwhile.
// Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module neighbor_table_aging_scan (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration
    input  wire logic                                   i_cfg_we,
    input  wire logic [ntas_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [ntas_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // input channel
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic                                   i_cmd,
    input  wire logic                                   i_family,
    input  wire logic [9:0]                             i_entry_index,
    input  wire logic                                   i_entry_valid,
    input  wire logic                                   i_entry_static,
    input  wire logic [ntas_pkg::TIME_W-1:0]            i_entry_time,
    input  wire logic [ntas_pkg::TIME_W-1:0]            i_now,
    // output channel
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [1:0]                                  o_action,
    output logic                                        o_result_family,
    output logic [ntas_pkg::RES_IDX_W-1:0]              o_result_index,
    output logic                                        o_pass_complete,
    output logic                                        o_last
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACK,
        S_SCAN,
        S_EVAL,
        S_FIN
    } t_state;

    t_state r_state;

    // configuration registers
    logic [1:0]                      r_scan_mode;
    logic [ntas_pkg::TIME_W-1:0]     r_scan_interval;
    logic [ntas_pkg::TIME_W-1:0]     r_stale_thresh;
    logic [ntas_pkg::UPD_W-1:0]      r_upd_budget;
    logic [ntas_pkg::VIS_W-1:0]      r_max_visits;

    // scan state
    ntas_pkg::t_cur                  r_cur4;
    ntas_pkg::t_cur                  r_cur6;
    logic                            r_purge4;
    logic                            r_purge6;
    logic [ntas_pkg::UPD_W-1:0]      r_updates;
    logic [ntas_pkg::VIS_W-1:0]      r_visits;
    logic                            r_fam;
    logic [ntas_pkg::TIME_W-1:0]     r_now;
    ntas_pkg::t_idx                  r_clr_idx;
    logic                            r_ack_fam;
    logic [ntas_pkg::RES_IDX_W-1:0]  r_ack_idx;

    // output register
    logic                            r_o_valid;
    ntas_pkg::t_action               r_o_action;
    logic                            r_o_family;
    logic [ntas_pkg::RES_IDX_W-1:0]  r_o_index;
    logic                            r_o_pc;
    logic                            r_o_last;

    // tables
    ntas_pkg::t_slot                 mem4 [ntas_pkg::TABLE_DEPTH];
    ntas_pkg::t_slot                 mem6 [ntas_pkg::TABLE_DEPTH];
    ntas_pkg::t_slot                 r_rd4;
    ntas_pkg::t_slot                 r_rd6;

    logic                            wr_en4;
    logic                            wr_en6;
    ntas_pkg::t_idx                  wr_addr;
    ntas_pkg::t_slot                 wr_data;

    logic                            in_accept;
    logic                            out_free;
    logic                            out_load;
    logic                            in_range;
    ntas_pkg::t_slot                 rd;
    ntas_pkg::t_cur                  cur;
    ntas_pkg::t_cur                  cur_next;
    logic                            purge;
    logic [ntas_pkg::TIME_W-1:0]     age;
    logic                            budget_hit;
    logic                            is_del;
    logic                            is_probe;
    logic                            emit;
    logic                            pass_done;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_o_valid || !i_out_stall;
    assign in_range  = 32'(i_entry_index) < ntas_pkg::TABLE_DEPTH;

    // shared age unit: one subtract, two compares against the thresholds
    assign rd         = r_fam ? r_rd6 : r_rd4;
    assign cur        = r_fam ? r_cur6 : r_cur4;
    assign cur_next   = ntas_pkg::t_cur'(cur + 1'b1);
    assign purge      = r_fam ? r_purge6 : r_purge4;
    assign age        = r_now - rd.stamp;
    assign budget_hit = (r_updates >= r_upd_budget) || (r_visits >= r_max_visits);
    assign is_del     = !rd.stat && purge && (age >= r_stale_thresh);
    assign is_probe   = !rd.stat && !is_del && (age >= r_scan_interval);
    assign emit       = rd.valid && !budget_hit && (is_del || is_probe);
    assign pass_done  = (r_cur4 == ntas_pkg::CUR_DONE) && (r_cur6 == ntas_pkg::CUR_DONE);

    // a new transaction enters the output register this cycle
    assign out_load   = out_free && ((r_state == S_ACK) || (r_state == S_FIN) ||
                                     ((r_state == S_EVAL) && emit));

    // table write port: clearing sweep, write command or delete
    always_comb begin
        wr_en4  = 1'b0;
        wr_en6  = 1'b0;
        wr_addr = r_clr_idx;
        wr_data = '0;
        if (r_state == S_CLEAR) begin
            wr_en4 = 1'b1;
            wr_en6 = 1'b1;
        end else if (in_accept && (i_cmd == ntas_pkg::CMD_WRITE) && in_range) begin
            wr_en4  = !i_family;
            wr_en6  = i_family;
            wr_addr = ntas_pkg::t_idx'(i_entry_index);
            wr_data = '{valid: i_entry_valid, stat: i_entry_static, stamp: i_entry_time};
        end else if ((r_state == S_EVAL) && emit && is_del && out_free) begin
            wr_en4  = !r_fam;
            wr_en6  = r_fam;
            wr_addr = cur[ntas_pkg::IDX_W-1:0];
            wr_data = '{valid: 1'b0, stat: rd.stat, stamp: rd.stamp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en4) begin
            mem4[wr_addr] <= wr_data;
        end
        r_rd4 <= mem4[r_cur4[ntas_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en6) begin
            mem6[wr_addr] <= wr_data;
        end
        r_rd6 <= mem6[r_cur6[ntas_pkg::IDX_W-1:0]];
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_mode     <= ntas_pkg::RST_SCAN_MODE;
            r_scan_interval <= ntas_pkg::RST_SCAN_INTERVAL;
            r_stale_thresh  <= ntas_pkg::RST_STALE_THRESH;
            r_upd_budget    <= ntas_pkg::RST_UPD_BUDGET;
            r_max_visits    <= ntas_pkg::RST_MAX_VISITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ntas_pkg::CFG_SCAN_MODE:     r_scan_mode     <= i_cfg_data[1:0];
                ntas_pkg::CFG_SCAN_INTERVAL: r_scan_interval <= i_cfg_data;
                ntas_pkg::CFG_STALE_THRESH:  r_stale_thresh  <= i_cfg_data;
                ntas_pkg::CFG_UPD_BUDGET:    r_upd_budget    <= i_cfg_data[ntas_pkg::UPD_W-1:0];
                ntas_pkg::CFG_MAX_VISITS:    r_max_visits    <= i_cfg_data[ntas_pkg::VIS_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_cur4    <= '0;
            r_cur6    <= '0;
            r_purge4  <= 1'b0;
            r_purge6  <= 1'b0;
            r_updates <= '0;
            r_visits  <= '0;
            r_fam     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && !i_out_stall && !out_load) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= ntas_pkg::t_idx'(r_clr_idx + 1'b1);
                    if (r_clr_idx == ntas_pkg::t_idx'(ntas_pkg::TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_cmd == ntas_pkg::CMD_WRITE) begin
                            r_ack_fam <= i_family;
                            r_ack_idx <= i_entry_index;
                            r_state   <= S_ACK;
                        end else begin
                            r_now     <= i_now;
                            r_updates <= '0;
                            r_visits  <= '0;
                            r_fam     <= 1'b0;
                            if (!r_scan_mode[0]) begin
                                r_cur4 <= ntas_pkg::CUR_DONE;
                            end
                            if (!r_scan_mode[1]) begin
                                r_cur6 <= ntas_pkg::CUR_DONE;
                            end
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_ACK: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_action <= ntas_pkg::ACT_ACK;
                        r_o_family <= r_ack_fam;
                        r_o_index  <= r_ack_idx;
                        r_o_pc     <= 1'b0;
                        r_o_last   <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    // the slot at the cursor is read during this cycle
                    if (cur == ntas_pkg::CUR_DONE) begin
                        if (!r_fam) begin
                            r_fam <= 1'b1;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (rd.valid && budget_hit) begin
                        // park the cursor on this entry, move on to the next family or finish the run
                        if (!r_fam) begin
                            r_fam   <= 1'b1;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else if (!emit || out_free) begin
                        if (emit) begin
                            r_o_valid  <= 1'b1;
                            r_o_action <= is_del ? ntas_pkg::ACT_DELETE : ntas_pkg::ACT_PROBE;
                            r_o_family <= r_fam;
                            r_o_index  <= ntas_pkg::RES_IDX_W'(cur);
                            r_o_pc     <= 1'b0;
                            r_o_last   <= 1'b0;
                            r_updates  <= ntas_pkg::UPD_W'(r_updates + 1'b1);
                        end
                        if (rd.valid) begin
                            r_visits <= ntas_pkg::VIS_W'(r_visits + 1'b1);
                        end
                        if (r_fam) begin
                            r_cur6 <= cur_next;
                        end else begin
                            r_cur4 <= cur_next;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_action <= ntas_pkg::ACT_DONE;
                        r_o_family <= 1'b0;
                        r_o_index  <= '0;
                        r_o_pc     <= pass_done;
                        r_o_last   <= 1'b1;
                        if (pass_done) begin
                            // rewind for the next pass, arm purge on scanned families
                            r_cur4   <= '0;
                            r_cur6   <= '0;
                            r_purge4 <= r_scan_mode[0];
                            r_purge6 <= r_scan_mode[1];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_o_valid;
    assign o_action        = r_o_action;
    assign o_result_family = r_o_family;
    assign o_result_index  = r_o_index;
    assign o_pass_complete = r_o_pc;
    assign o_last          = r_o_last;

endmodule
`default_nettype wire
